// File: rtl/gjmi_pkg.sv
// Package: shared constants, types and helpers for the matrix inverter.
`timescale 1ns / 1ps
`default_nettype none
package gjmi_pkg;
   localparam int MAX_SIZE_DEF = 4;
   localparam int DATA_W = 32;
   localparam int SIZE_W = 3;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;
   localparam int QFRAC = 16;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PIV_RD,
      ST_PIV_WAIT,
      ST_FIX,
      ST_DIV,
      ST_FAC_RD,
      ST_FAC_WAIT,
      ST_ELIM,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_ISSUE,
      PH_WAIT,
      PH_CALC,
      PH_WRITE
   } phase_type;

   localparam logic [DATA_W-1:0] S32_MAX = 32'h7fffffff;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h80000000;

   function automatic logic [DATA_W-1:0] sat64(input logic signed [63:0] v);
      logic [DATA_W-1:0] r;
      if (v > 64'sd2147483647) r = S32_MAX;
      else if (v < -64'sd2147483648) r = S32_MIN;
      else r = v[DATA_W-1:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// File: rtl/gjmi_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module gjmi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  addr,
   input  wire [WIDTH-1:0]          wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// File: rtl/gjmi_div.sv
// Restoring divider: signed 64 by 32 truncating quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gjmi_div (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire signed [63:0]  dividend,
   input  wire signed [31:0]  divisor,
   output logic               done,
   output logic signed [63:0] quotient
);
   logic [63:0] num_ff, num_in;
   logic [64:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[63:0], num_ff[63]};
      trial   = shifted - {33'd0, den_ff};
      done    = 1'b0;
      if (start) begin
         num_in  = dividend[63] ? 64'(-dividend) : 64'(dividend);
         den_in  = divisor[31] ? 32'(-divisor) : 32'(divisor);
         neg_in  = dividend[63] ^ divisor[31];
         rem_in  = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial;
            num_in = {num_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            num_in = {num_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   assign quotient = neg_ff ? -$signed(num_in) : $signed(num_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end
endmodule
`default_nettype wire

// File: rtl/gauss_jordan_matrix_inverse.sv
// Top level: Gauss-Jordan inverter of an n by 2n Q16.16 augmented matrix.
//
// Words enter on req_ (element, last) one per cycle while loading and are
// stored row-major in one RAM. A word with last set starts elimination; the
// block then holds req_ready low until all 2n*n result words have left on
// rsp_ (value, final_element, singular), row-major.
// Elimination walks the RAM: per pivot column the pivot is read, a zero
// pivot is fixed by adding a neighbor row, the pivot row is divided element
// by element through the bit-serial divider, then each row but the pivot row
// takes a read, a registered multiply and a write back. Emission reads one
// element, waits for the receiver, and reads the next only once it is taken.
// A stalled receiver holds the output register and the RAM walk.
// Reset returns to loading with a zero count and matrix_size 4; RAM
// contents are left as they are.
// csr_: APB register 0 at address 0 is matrix_size (3 bits).
`timescale 1ns / 1ps
`default_nettype none
module gauss_jordan_matrix_inverse #(
   parameter int MAX_SIZE = gjmi_pkg::MAX_SIZE_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire signed [31:0]           req_element,
   input  wire                         req_last,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic signed [31:0]          rsp_value,
   output logic                        rsp_final_element,
   output logic                        rsp_singular,
   input  wire                         csr_psel,
   input  wire                         csr_penable,
   input  wire                         csr_pwrite,
   input  wire                         csr_paddr,
   input  wire [31:0]                  csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   localparam int DEPTH = 2 * MAX_SIZE * MAX_SIZE;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(2 * MAX_SIZE);
   localparam int RW = $clog2(MAX_SIZE);

   logic [gjmi_pkg::SIZE_W-1:0] size_ff;
   logic [gjmi_pkg::SIZE_W-1:0] n;
   logic [CW-1:0] total;
   logic [IW:0]   w;

   assign csr_pready = 1'b1;
   assign csr_prdata = {29'd0, size_ff};
   always_ff @(posedge clock) begin
      if (reset) size_ff <= gjmi_pkg::SIZE_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr)
         size_ff <= csr_pwdata[gjmi_pkg::SIZE_W-1:0];
   end

   always_comb begin
      n = size_ff;
      if (n < 3'd2) n = 3'd2;
      if (32'(n) > MAX_SIZE) n = gjmi_pkg::SIZE_W'(MAX_SIZE);
      w = (IW+1)'(2 * n);
      total = CW'(2 * n * n);
   end

   gjmi_pkg::state_type state_ff, state_in;
   gjmi_pkg::phase_type ph_ff, ph_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] m_ff, m_in, k_ff, k_in;
   logic [IW-1:0] i_ff, i_in;
   logic [31:0]   piv_ff, piv_in, fac_ff, fac_in, a_ff, a_in;
   logic signed [63:0] prod_ff, prod_in;
   logic          sing_ff, sing_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic          ov_ff, ov_in;
   logic [31:0]   ov_val_ff, ov_val_in;
   logic          ov_fin_ff, ov_fin_in;

   logic          we;
   logic [AW-1:0] addr;
   logic [31:0]   wdata, rdata;
   logic          div_start, div_done;
   logic signed [63:0] div_q;

   gjmi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   gjmi_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({{16{rdata[31]}}, rdata, 16'd0}), .divisor(piv_ff),
      .done(div_done), .quotient(div_q)
   );

   logic [RW-1:0] src;
   logic [AW-1:0] base_m, base_k, base_s;
   logic [IW-1:0] wlast;
   logic [RW-1:0] nlast;
   always_comb begin
      nlast  = RW'(n - 3'd1);
      wlast  = IW'(w - 1'b1);
      src    = (m_ff == nlast) ? m_ff - 1'b1 : m_ff + 1'b1;
      base_m = AW'(32'(m_ff) * 32'(w));
      base_k = AW'(32'(k_ff) * 32'(w));
      base_s = AW'(32'(src) * 32'(w));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gjmi_pkg::ST_LOAD:
            if (req_valid && req_last) state_in = gjmi_pkg::ST_PIV_RD;
         gjmi_pkg::ST_PIV_RD:    state_in = gjmi_pkg::ST_PIV_WAIT;
         gjmi_pkg::ST_PIV_WAIT:
            state_in = (rdata == 32'd0 && !ov_ff) ?
                       gjmi_pkg::ST_FIX : gjmi_pkg::ST_DIV;
         gjmi_pkg::ST_FIX:
            if (ph_ff == gjmi_pkg::PH_WRITE && i_ff == wlast)
               state_in = gjmi_pkg::ST_DIV;
         gjmi_pkg::ST_DIV:
            if (ph_ff == gjmi_pkg::PH_WRITE && i_ff == wlast)
               state_in = gjmi_pkg::ST_FAC_RD;
         gjmi_pkg::ST_FAC_RD:
            if (k_ff == m_ff) state_in = gjmi_pkg::ST_FAC_RD;
            else state_in = gjmi_pkg::ST_FAC_WAIT;
         gjmi_pkg::ST_FAC_WAIT:  state_in = gjmi_pkg::ST_ELIM;
         gjmi_pkg::ST_ELIM:
            if (ph_ff == gjmi_pkg::PH_WRITE && i_ff == wlast)
               state_in = gjmi_pkg::ST_FAC_RD;
         gjmi_pkg::ST_EMIT:
            if (ph_ff == gjmi_pkg::PH_WRITE && rsp_ready && emit_ff == total - 1'b1)
               state_in = gjmi_pkg::ST_LOAD;
         default: state_in = gjmi_pkg::ST_LOAD;
      endcase
      if (state_ff == gjmi_pkg::ST_FAC_RD && k_ff == m_ff && k_ff == nlast)
         state_in = (m_ff == nlast) ? gjmi_pkg::ST_EMIT : gjmi_pkg::ST_PIV_RD;
      if (state_ff == gjmi_pkg::ST_ELIM && ph_ff == gjmi_pkg::PH_WRITE &&
          i_ff == wlast && k_ff == nlast)
         state_in = (m_ff == nlast) ? gjmi_pkg::ST_EMIT : gjmi_pkg::ST_PIV_RD;
      if (state_ff == gjmi_pkg::ST_ELIM && ph_ff == gjmi_pkg::PH_WRITE &&
          i_ff == wlast && k_ff + 1'b1 == m_ff && m_ff == nlast)
         state_in = gjmi_pkg::ST_EMIT;
   end

   logic signed [63:0] sub;
   always_comb begin
      ph_in = ph_ff; cnt_in = cnt_ff; m_in = m_ff; k_in = k_ff; i_in = i_ff;
      piv_in = piv_ff; fac_in = fac_ff; a_in = a_ff; prod_in = prod_ff;
      sing_in = sing_ff; emit_in = emit_ff;
      ov_in = ov_ff; ov_val_in = ov_val_ff; ov_fin_in = ov_fin_ff;
      we = 1'b0; addr = '0; wdata = '0; div_start = 1'b0;
      req_ready = 1'b0; rsp_valid = 1'b0;
      rsp_value = '0; rsp_final_element = 1'b0; rsp_singular = sing_ff;
      sub = '0;
      case (state_ff)
         gjmi_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            addr = AW'(cnt_ff);
            wdata = req_element;
            if (req_valid) begin
               if (cnt_ff < total) begin
                  we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_last) begin
                  m_in = '0; sing_in = 1'b0; ov_in = 1'b0;
               end
            end
         end
         gjmi_pkg::ST_PIV_RD: begin
            addr = base_m + AW'(m_ff);
            ov_in = 1'b0; piv_in = 32'd1;
         end
         gjmi_pkg::ST_PIV_WAIT: begin
            piv_in = rdata; i_in = '0; ph_in = gjmi_pkg::PH_ISSUE;
         end
         gjmi_pkg::ST_FIX: begin
            unique case (ph_ff)
               gjmi_pkg::PH_ISSUE: begin
                  addr = base_s + AW'(i_ff); ph_in = gjmi_pkg::PH_WAIT;
               end
               gjmi_pkg::PH_WAIT: begin
                  a_in = rdata; addr = base_m + AW'(i_ff);
                  ph_in = gjmi_pkg::PH_CALC;
               end
               gjmi_pkg::PH_CALC: begin
                  a_in = gjmi_pkg::sat64(64'($signed(a_ff)) + 64'($signed(rdata)));
                  ph_in = gjmi_pkg::PH_WRITE;
               end
               gjmi_pkg::PH_WRITE: begin
                  we = 1'b1; addr = base_m + AW'(i_ff); wdata = a_ff;
                  if (i_ff == IW'(m_ff)) piv_in = a_ff;
                  ph_in = gjmi_pkg::PH_ISSUE;
                  i_in = (i_ff == wlast) ? '0 : i_ff + 1'b1;
               end
               default: ph_in = gjmi_pkg::PH_ISSUE;
            endcase
         end
         gjmi_pkg::ST_DIV: begin
            unique case (ph_ff)
               gjmi_pkg::PH_ISSUE: begin
                  addr = base_m + AW'(i_ff); ph_in = gjmi_pkg::PH_WAIT;
               end
               gjmi_pkg::PH_WAIT: begin
                  a_in = rdata;
                  if (piv_ff == 32'd0) begin
                     sing_in = 1'b1;
                     a_in = rdata[31] ? gjmi_pkg::S32_MIN :
                            (rdata == 32'd0 ? 32'd0 : gjmi_pkg::S32_MAX);
                     ph_in = gjmi_pkg::PH_WRITE;
                  end else ph_in = gjmi_pkg::PH_CALC;
                  div_start = (piv_ff != 32'd0);
               end
               gjmi_pkg::PH_CALC: begin
                  if (div_done) begin
                     a_in = gjmi_pkg::sat64(div_q); ph_in = gjmi_pkg::PH_WRITE;
                  end
               end
               gjmi_pkg::PH_WRITE: begin
                  we = 1'b1; addr = base_m + AW'(i_ff); wdata = a_ff;
                  ph_in = gjmi_pkg::PH_ISSUE;
                  i_in = (i_ff == wlast) ? '0 : i_ff + 1'b1;
                  if (i_ff == wlast) k_in = '0;
               end
               default: ph_in = gjmi_pkg::PH_ISSUE;
            endcase
         end
         gjmi_pkg::ST_FAC_RD: begin
            addr = base_k + AW'(m_ff);
            if (k_ff == m_ff) begin
               if (k_ff == nlast) m_in = m_ff + 1'b1;
               else k_in = k_ff + 1'b1;
               if (k_ff == nlast) emit_in = '0;
            end
         end
         gjmi_pkg::ST_FAC_WAIT: begin
            fac_in = rdata; i_in = '0; ph_in = gjmi_pkg::PH_ISSUE;
         end
         gjmi_pkg::ST_ELIM: begin
            unique case (ph_ff)
               gjmi_pkg::PH_ISSUE: begin
                  addr = base_m + AW'(i_ff); ph_in = gjmi_pkg::PH_WAIT;
               end
               gjmi_pkg::PH_WAIT: begin
                  prod_in = 64'($signed(rdata)) * 64'($signed(fac_ff));
                  addr = base_k + AW'(i_ff); ph_in = gjmi_pkg::PH_CALC;
               end
               gjmi_pkg::PH_CALC: begin
                  sub = (prod_ff + (prod_ff[63] ? 64'sd65535 : 64'sd0)) >>> 16;
                  a_in = gjmi_pkg::sat64(64'($signed(rdata)) - sub);
                  ph_in = gjmi_pkg::PH_WRITE;
               end
               gjmi_pkg::PH_WRITE: begin
                  we = 1'b1; addr = base_k + AW'(i_ff); wdata = a_ff;
                  ph_in = gjmi_pkg::PH_ISSUE;
                  i_in = (i_ff == wlast) ? '0 : i_ff + 1'b1;
                  if (i_ff == wlast) begin
                     emit_in = '0;
                     if (k_ff == nlast || (k_ff + 1'b1 == m_ff && m_ff == nlast)) begin
                        m_in = m_ff + 1'b1; k_in = '0;
                     end else k_in = k_ff + 1'b1;
                  end
               end
               default: ph_in = gjmi_pkg::PH_ISSUE;
            endcase
         end
         gjmi_pkg::ST_EMIT: begin
            rsp_value = ov_val_ff; rsp_final_element = ov_fin_ff;
            unique case (ph_ff)
               gjmi_pkg::PH_ISSUE: begin
                  addr = AW'(emit_ff); ph_in = gjmi_pkg::PH_WAIT;
               end
               gjmi_pkg::PH_WAIT: begin
                  ov_val_in = rdata; ov_fin_in = (emit_ff == total - 1'b1);
                  ph_in = gjmi_pkg::PH_WRITE;
               end
               gjmi_pkg::PH_WRITE: begin
                  rsp_valid = 1'b1;
                  if (rsp_ready) begin
                     ph_in = gjmi_pkg::PH_ISSUE;
                     emit_in = emit_ff + 1'b1;
                     if (emit_ff == total - 1'b1) cnt_in = '0;
                  end
               end
               default: ph_in = gjmi_pkg::PH_ISSUE;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gjmi_pkg::ST_LOAD;
         ph_ff <= gjmi_pkg::PH_ISSUE;
         cnt_ff <= '0; m_ff <= '0; k_ff <= '0; i_ff <= '0;
         sing_ff <= 1'b0; emit_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ph_ff <= ph_in;
         cnt_ff <= cnt_in; m_ff <= m_in; k_ff <= k_in; i_ff <= i_in;
         sing_ff <= sing_in; emit_ff <= emit_in; ov_ff <= ov_in;
      end
      piv_ff <= piv_in; fac_ff <= fac_in; a_ff <= a_in; prod_ff <= prod_in;
      ov_val_ff <= ov_val_in; ov_fin_ff <= ov_fin_in;
   end
endmodule
`default_nettype wire
